@@ rtl/kmer_histogram_counter_unit_defines.svh @@
// Assertion macros shared by the k-mer histogram counter RTL.
`ifndef KMER_HISTOGRAM_COUNTER_UNIT_DEFINES_SVH
`define KMER_HISTOGRAM_COUNTER_UNIT_DEFINES_SVH

`ifndef SYNTH

`define KHC_ASSERT_IMPL(lbl, clk_i, rstn_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |-> (cons)) \
    else $error("assertion failed");

`define KHC_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define KHC_ASSERT_IMPL(lbl, clk_i, rstn_i, ante, cons)
`define KHC_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons)

`endif

`endif

@@ rtl/khc_pkg.sv @@
// Types and constants of the k-mer histogram counter.
`default_nettype none
package khc_pkg;

  localparam logic [1:0] FUNC_PUSH   = 2'd0;
  localparam logic [1:0] FUNC_READ   = 2'd1;
  localparam logic [1:0] FUNC_NEWSEQ = 2'd2;

  localparam logic [3:0] KMER_LEN_RESET = 4'd3;
  localparam logic [3:0] RUN_MAX        = 4'hF;

  localparam int MID_DEPTH = 2;
  localparam int RES_DEPTH = 4;

  localparam int WORD_W  = 16;
  localparam int VALUE_W = 32;
  localparam int RES_W   = 1 + WORD_W + VALUE_W;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INC,
    OP_CLEAR
  } op_kind_t;

  typedef struct packed {
    logic                 counted;
    logic [WORD_W-1:0]    word_index;
    logic [VALUE_W-1:0]   count_value;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/khc_queue.sv @@
// Small first-in first-out queue of packed words.
`default_nettype none
module khc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         push,
  input  wire  [WIDTH-1:0]            wdata,
  input  wire                         pop,
  output logic [WIDTH-1:0]            rdata,
  output logic                        full,
  output logic                        empty,
  output logic [$clog2(DEPTH+1)-1:0]  count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign rdata   = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

@@ rtl/khc_front.sv @@
// Front end: word length register, symbol window and item classification.
`default_nettype none
module khc_front #(
  parameter int MAX_WORD_LEN = 8
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire  [3:0]                    cfg_kmer_length,
  input  wire                           accept,
  input  wire  [1:0]                    func,
  input  wire  [1:0]                    symbol,
  input  wire                           symbol_invalid,
  input  wire  [khc_pkg::WORD_W-1:0]    bin_index,
  output khc_pkg::op_kind_t             op_kind,
  output logic [2*MAX_WORD_LEN-1:0]     op_addr
);

  localparam int WIN_BITS = 2 * MAX_WORD_LEN;

  logic [3:0]          kmer_len_r;
  logic [3:0]          k_eff;
  logic [WIN_BITS-1:0] win_r, win_nxt;
  logic [3:0]          run_r, run_nxt;
  logic [WIN_BITS-1:0] kmask;
  logic [WIN_BITS+khc_pkg::WORD_W-1:0] req_wide;
  logic [WIN_BITS-1:0] req_addr;

  assign cfg_ready = 1'b1;
  assign req_wide  = {{WIN_BITS{1'b0}}, bin_index};
  assign req_addr  = req_wide[WIN_BITS-1:0];

  always_comb begin
    priority if (kmer_len_r == 4'd0) begin
      k_eff = 4'd1;
    end else if (kmer_len_r > 4'(MAX_WORD_LEN)) begin
      k_eff = 4'(MAX_WORD_LEN);
    end else begin
      k_eff = kmer_len_r;
    end
  end

  assign kmask = ~({WIN_BITS{1'b1}} << {k_eff, 1'b0});

  always_comb begin
    win_nxt = win_r;
    run_nxt = run_r;
    op_kind = khc_pkg::OP_NONE;
    op_addr = '0;
    unique case (func)
      khc_pkg::FUNC_PUSH: begin
        if (symbol_invalid) begin
          win_nxt = win_r << 2;
          run_nxt = '0;
        end else begin
          win_nxt = (win_r << 2) | WIN_BITS'(symbol);
          run_nxt = (run_r == khc_pkg::RUN_MAX) ? run_r : run_r + 4'd1;
          if (run_nxt >= k_eff) begin
            op_kind = khc_pkg::OP_INC;
            op_addr = win_nxt & kmask;
          end
        end
      end
      khc_pkg::FUNC_READ: begin
        op_kind = khc_pkg::OP_CLEAR;
        op_addr = req_addr;
      end
      khc_pkg::FUNC_NEWSEQ: begin
        win_nxt = '0;
        run_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kmer_len_r <= khc_pkg::KMER_LEN_RESET;
      win_r      <= '0;
      run_r      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        kmer_len_r <= cfg_kmer_length;
      end
      if (accept) begin
        win_r <= win_nxt;
        run_r <= run_nxt;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/khc_back.sv @@
// Back end: count memory, clearing sweep, read-modify-write stage and result queue.
`default_nettype none
`include "kmer_histogram_counter_unit_defines.svh"
module khc_back #(
  parameter int MAX_WORD_LEN = 8,
  parameter int COUNT_BITS   = 32
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           op_empty,
  input  var khc_pkg::op_kind_t         op_kind,
  input  wire  [2*MAX_WORD_LEN-1:0]     op_addr,
  output logic                          op_pop,
  output logic                          busy,
  input  wire                           res_pop,
  output logic                          res_empty,
  output khc_pkg::result_t              res_word
);

  localparam int WIN_BITS = 2 * MAX_WORD_LEN;
  localparam int NUM_BINS = 1 << WIN_BITS;
  localparam int CNT_W    = $clog2(khc_pkg::RES_DEPTH + 1);

  logic [COUNT_BITS-1:0] mem [NUM_BINS];

  logic                  clr_active_r;
  logic [WIN_BITS-1:0]   clr_addr_r;
  logic                  a_valid_r;
  khc_pkg::op_kind_t     a_kind_r;
  logic [WIN_BITS-1:0]   a_addr_r;
  logic [COUNT_BITS-1:0] rd_data_r;
  logic                  fwd_r;
  logic [COUNT_BITS-1:0] fwd_data_r;

  logic [COUNT_BITS-1:0] old_val, new_val;
  logic                  a_writes;
  logic                  wr_en;
  logic [WIN_BITS-1:0]   wr_addr;
  logic [COUNT_BITS-1:0] wr_data;
  logic                  credit_ok;
  logic [CNT_W-1:0]      res_count;
  logic                  res_full;
  khc_pkg::result_t      res_in;
  logic [WIN_BITS+khc_pkg::WORD_W-1:0]    word_wide;
  logic [COUNT_BITS+khc_pkg::VALUE_W-1:0] value_wide;
  logic [khc_pkg::RES_W-1:0] res_rdata;

  assign busy      = clr_active_r;
  assign credit_ok = ({1'b0, res_count} + (CNT_W + 1)'(a_valid_r))
                     < (CNT_W + 1)'(khc_pkg::RES_DEPTH);
  assign op_pop    = !op_empty && !clr_active_r && credit_ok;

  assign old_val  = fwd_r ? fwd_data_r : rd_data_r;
  assign a_writes = a_valid_r && (a_kind_r != khc_pkg::OP_NONE);

  always_comb begin
    unique case (a_kind_r)
      khc_pkg::OP_INC:   new_val = (&old_val) ? old_val : old_val + COUNT_BITS'(1);
      khc_pkg::OP_CLEAR: new_val = '0;
      default:           new_val = old_val;
    endcase
  end

  assign wr_en   = clr_active_r || a_writes;
  assign wr_addr = clr_active_r ? clr_addr_r : a_addr_r;
  assign wr_data = clr_active_r ? '0 : new_val;

  assign word_wide  = {{khc_pkg::WORD_W{1'b0}}, a_addr_r};
  assign value_wide = {{khc_pkg::VALUE_W{1'b0}},
                       (a_kind_r == khc_pkg::OP_CLEAR) ? old_val : {COUNT_BITS{1'b0}}};

  always_comb begin
    res_in.counted     = (a_kind_r == khc_pkg::OP_INC);
    res_in.word_index  = word_wide[khc_pkg::WORD_W-1:0];
    res_in.count_value = value_wide[khc_pkg::VALUE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      a_valid_r    <= 1'b0;
      fwd_r        <= 1'b0;
    end else begin
      if (clr_active_r) begin
        clr_addr_r <= clr_addr_r + WIN_BITS'(1);
        if (&clr_addr_r) begin
          clr_active_r <= 1'b0;
        end
      end
      a_valid_r <= op_pop;
      fwd_r     <= op_pop && a_writes && (a_addr_r == op_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop) begin
      a_kind_r   <= op_kind;
      a_addr_r   <= op_addr;
      fwd_data_r <= new_val;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (op_pop) begin
      rd_data_r <= mem[op_addr];
    end
  end

  khc_queue #(
    .WIDTH (khc_pkg::RES_W),
    .DEPTH (khc_pkg::RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (a_valid_r),
    .wdata (res_in),
    .pop   (res_pop),
    .rdata (res_rdata),
    .full  (res_full),
    .empty (res_empty),
    .count (res_count)
  );

  assign res_word = khc_pkg::result_t'(res_rdata);

  `KHC_ASSERT_IMPL(a_res_no_overflow, clk, rst_n, a_valid_r, !res_full)
  `KHC_ASSERT_NEXT(a_clear_done_stays, clk, rst_n, !clr_active_r, !clr_active_r)
  `KHC_ASSERT_IMPL(a_stage_from_pop, clk, rst_n, a_valid_r, $past(op_pop))

endmodule
`default_nettype wire

@@ rtl/kmer_histogram_counter_unit.sv @@
// Top level of the streaming DNA k-mer histogram counter.
// Takes one word per cycle while in_full is low and returns one result word per item,
// in order; repeated bins run back to back through the forwarded read-modify-write of
// the count memory, whose single write port sets the rate of one item per cycle while
// the result queue has room. After reset all 4**MAX_WORD_LEN bins are swept to zero,
// one bin a cycle; in_full stays high over the sweep while cfg writes are taken.
`default_nettype none
`include "kmer_histogram_counter_unit_defines.svh"
module kmer_histogram_counter_unit #(
  parameter int MAX_WORD_LEN = 8,
  parameter int COUNT_BITS   = 32
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [3:0]                   cfg_kmer_length,
  input  wire                          in_push,
  output logic                         in_full,
  input  wire  [1:0]                   in_func,
  input  wire  [1:0]                   in_symbol,
  input  wire                          in_symbol_invalid,
  input  wire  [15:0]                  in_bin_index,
  output logic                         out_empty,
  input  wire                          out_pop,
  output logic                         out_counted,
  output logic [15:0]                  out_word_index,
  output logic [31:0]                  out_count_value
);

  localparam int WIN_BITS = 2 * MAX_WORD_LEN;
  localparam int OP_W     = 2 + WIN_BITS;

  logic                 accept;
  logic                 busy;
  khc_pkg::op_kind_t    fe_kind;
  logic [WIN_BITS-1:0]  fe_addr;
  logic                 mid_full, mid_empty, mid_pop;
  logic [OP_W-1:0]      mid_rdata;
  logic [$clog2(khc_pkg::MID_DEPTH+1)-1:0] mid_count;
  khc_pkg::result_t     res_word;

  assign in_full = busy || mid_full;
  assign accept  = in_push && !in_full;

  khc_front #(
    .MAX_WORD_LEN (MAX_WORD_LEN)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_kmer_length (cfg_kmer_length),
    .accept          (accept),
    .func            (in_func),
    .symbol          (in_symbol),
    .symbol_invalid  (in_symbol_invalid),
    .bin_index       (in_bin_index),
    .op_kind         (fe_kind),
    .op_addr         (fe_addr)
  );

  khc_queue #(
    .WIDTH (OP_W),
    .DEPTH (khc_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (accept),
    .wdata ({fe_kind, fe_addr}),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .full  (mid_full),
    .empty (mid_empty),
    .count (mid_count)
  );

  khc_back #(
    .MAX_WORD_LEN (MAX_WORD_LEN),
    .COUNT_BITS   (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_empty  (mid_empty),
    .op_kind   (khc_pkg::op_kind_t'(mid_rdata[OP_W-1:WIN_BITS])),
    .op_addr   (mid_rdata[WIN_BITS-1:0]),
    .op_pop    (mid_pop),
    .busy      (busy),
    .res_pop   (out_pop),
    .res_empty (out_empty),
    .res_word  (res_word)
  );

  assign out_counted     = res_word.counted;
  assign out_word_index  = res_word.word_index;
  assign out_count_value = res_word.count_value;

  `KHC_ASSERT_IMPL(a_mid_count_bound, clk, rst_n, 1'b1,
                   mid_count <= ($clog2(khc_pkg::MID_DEPTH+1))'(khc_pkg::MID_DEPTH))
  `KHC_ASSERT_IMPL(a_no_accept_in_sweep, clk, rst_n, busy, !accept && mid_empty)
  `KHC_ASSERT_NEXT(a_accept_reaches_queue, clk, rst_n, accept, !mid_empty)

endmodule
`default_nettype wire

@@ verif/kmer_histogram_counter_unit_tb.sv @@
// Self-checking testbench for the k-mer histogram counter unit, predicting every result word.
module kmer_histogram_counter_unit_tb;

  localparam int MAX_WORD_LEN = 8;
  localparam int COUNT_BITS   = 32;
  localparam int WIN_W        = 2 * MAX_WORD_LEN;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int RECENT_DEPTH = 32;

  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam logic [1:0] NUC_A = 2'd0;
  localparam logic [1:0] NUC_C = 2'd1;
  localparam logic [1:0] NUC_G = 2'd2;
  localparam logic [1:0] NUC_T = 2'd3;

  localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_kmer_length;
  logic        in_push;
  logic        in_full;
  logic [1:0]  in_func;
  logic [1:0]  in_symbol;
  logic        in_symbol_invalid;
  logic [15:0] in_bin_index;
  logic        out_empty;
  logic        out_pop;
  logic        out_counted;
  logic [15:0] out_word_index;
  logic [31:0] out_count_value;

  logic [3:0]            kmer_len_q;
  logic [WIN_W-1:0]      window_q;
  logic [3:0]            run_q;
  bit [COUNT_BITS-1:0]   bin_tally [0:(1<<WIN_W)-1];
  khc_pkg::result_t      pending_results [$];
  logic [15:0]           recent_bins [$];

  int  mismatches;
  int  pop_hold_cycles;
  bit  gaps_on;

  kmer_histogram_counter_unit #(
    .MAX_WORD_LEN(MAX_WORD_LEN),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_kmer_length  (cfg_kmer_length),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_func          (in_func),
    .in_symbol        (in_symbol),
    .in_symbol_invalid(in_symbol_invalid),
    .in_bin_index     (in_bin_index),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_counted      (out_counted),
    .out_word_index   (out_word_index),
    .out_count_value  (out_count_value)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic khc_pkg::result_t predict_word(input logic [1:0] func,
                                                    input logic [1:0] sym,
                                                    input logic bad,
                                                    input logic [15:0] idx);
    khc_pkg::result_t res;
    int               k;
    logic [WIN_W-1:0] bin;
    res = '0;
    if (kmer_len_q == 4'd0) k = 1;
    else if (int'(kmer_len_q) > MAX_WORD_LEN) k = MAX_WORD_LEN;
    else k = int'(kmer_len_q);
    case (func)
      khc_pkg::FUNC_PUSH: begin
        if (bad) begin
          window_q = {window_q[WIN_W-3:0], 2'b00};
          run_q = '0;
        end else begin
          window_q = {window_q[WIN_W-3:0], sym};
          if (run_q != khc_pkg::RUN_MAX) run_q = run_q + 4'd1;
          if (int'(run_q) >= k) begin
            bin = window_q & WIN_W'((64'd1 << (2 * k)) - 64'd1);
            if (bin_tally[bin] != COUNT_TOP) bin_tally[bin] = bin_tally[bin] + 1'b1;
            res.counted = 1'b1;
            res.word_index = 16'(bin);
            recent_bins.push_back(16'(bin));
            if (recent_bins.size() > RECENT_DEPTH) void'(recent_bins.pop_front());
          end
        end
      end
      khc_pkg::FUNC_READ: begin
        bin = WIN_W'(idx);
        res.word_index = 16'(bin);
        res.count_value = 32'(bin_tally[bin]);
        bin_tally[bin] = '0;
      end
      khc_pkg::FUNC_NEWSEQ: begin
        window_q = '0;
        run_q = '0;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic send_word(input logic [1:0] func, input logic [1:0] sym, input logic bad,
                           input logic [15:0] idx);
    @(negedge clk);
    in_push <= 1'b1;
    in_func <= func;
    in_symbol <= sym;
    in_symbol_invalid <= bad;
    in_bin_index <= idx;
    do @(posedge clk); while (in_full);
    pending_results.push_back(predict_word(func, sym, bad, idx));
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      in_push <= 1'b0;
    end
  endtask

  task automatic maybe_gap();
    if (gaps_on && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 9));
  endtask

  task automatic drain_results();
    idle_cycles(1);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_kmer_length(input logic [3:0] len);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_kmer_length <= len;
    do @(posedge clk); while (!cfg_ready);
    kmer_len_q = len;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_code(input logic [1:0] sym);
    send_word(khc_pkg::FUNC_PUSH, sym, 1'b0, 16'($urandom_range(0, 65535)));
  endtask

  task automatic send_random_word();
    int          pick;
    logic [1:0]  sym;
    logic [15:0] idx;
    pick = $urandom_range(0, 99);
    sym = 2'($urandom_range(0, 3));
    idx = 16'($urandom_range(0, 65535));
    if (pick < 74) begin
      send_word(khc_pkg::FUNC_PUSH, sym, ($urandom_range(0, 19) == 0), idx);
    end else if (pick < 88) begin
      if (recent_bins.size() != 0 && $urandom_range(0, 3) != 0)
        idx = recent_bins[$urandom_range(0, recent_bins.size() - 1)];
      send_word(khc_pkg::FUNC_READ, sym, 1'($urandom_range(0, 1)), idx);
    end else if (pick < 96) begin
      send_word(khc_pkg::FUNC_NEWSEQ, sym, 1'($urandom_range(0, 1)), idx);
    end else begin
      send_word(FUNC_SPARE, sym, 1'($urandom_range(0, 1)), idx);
    end
  endtask

  task automatic test_short_words();
    set_kmer_length(4'd1);
    push_code(NUC_C);
    push_code(NUC_T);
    set_kmer_length(4'd0);
    push_code(NUC_G);
    send_word(khc_pkg::FUNC_READ, NUC_A, 1'b0, 16'h0002);
    send_word(khc_pkg::FUNC_READ, NUC_T, 1'b1, 16'h0003);
  endtask

  task automatic test_long_words();
    set_kmer_length(4'd8);
    send_word(khc_pkg::FUNC_NEWSEQ, NUC_T, 1'b1, 16'hFFFF);
    repeat (8) push_code(NUC_T);
    set_kmer_length(4'd15);
    push_code(NUC_A);
    send_word(khc_pkg::FUNC_READ, NUC_A, 1'b0, 16'hFFFF);
    send_word(khc_pkg::FUNC_READ, NUC_A, 1'b0, 16'hFFFC);
  endtask

  task automatic test_invalid_and_restart();
    set_kmer_length(4'd3);
    push_code(NUC_A);
    push_code(NUC_C);
    send_word(khc_pkg::FUNC_PUSH, NUC_T, 1'b1, 16'h0000);
    push_code(NUC_G);
    push_code(NUC_T);
    push_code(NUC_A);
    send_word(khc_pkg::FUNC_NEWSEQ, NUC_G, 1'b0, 16'h5555);
    push_code(NUC_C);
    send_word(FUNC_SPARE, NUC_T, 1'b1, 16'hAAAA);
    send_word(khc_pkg::FUNC_READ, NUC_C, 1'b0, 16'h002C);
  endtask

  task automatic test_backpressure();
    set_kmer_length(4'd2);
    gaps_on = 1'b0;
    pop_hold_cycles = 300;
    repeat (60) send_random_word();
    drain_results();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_phases();
    logic [3:0] lengths [10];
    lengths = '{4'd1, 4'd8, 4'd2, 4'd0, 4'd5, 4'd15, 4'd3, 4'd6, 4'd4, 4'd7};
    foreach (lengths[p]) begin
      set_kmer_length(lengths[p]);
      for (int n = 0; n < 170; n++) begin
        if (n % 50 == 0) gaps_on = ($urandom_range(0, 3) != 0);
        maybe_gap();
        send_random_word();
      end
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_steady_stream();
    set_kmer_length(4'($urandom_range(1, 8)));
    gaps_on = 1'b0;
    repeat (150) send_random_word();
  endtask

  initial begin : pop_driver
    int stall;
    stall = 0;
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (pop_hold_cycles > 0) begin
        out_pop <= 1'b0;
        pop_hold_cycles--;
      end else if (stall > 0) begin
        out_pop <= 1'b0;
        stall--;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        out_pop <= 1'b0;
        stall = $urandom_range(1, 9) - 1;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  initial begin : result_checker
    khc_pkg::result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: counted %0b index %h value %h",
                     out_counted, out_word_index, out_count_value);
        end else begin
          want = pending_results.pop_front();
          if (out_counted !== want.counted || out_word_index !== want.word_index ||
              out_count_value !== want.count_value) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected counted %0b index %h value %h, got %0b %h %h",
                       want.counted, want.word_index, want.count_value,
                       out_counted, out_word_index, out_count_value);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[kmer_histogram_counter_unit] ERROR");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_kmer_length = '0;
    in_push = 1'b0;
    in_func = khc_pkg::FUNC_PUSH;
    in_symbol = NUC_A;
    in_symbol_invalid = 1'b0;
    in_bin_index = '0;
    mismatches = 0;
    pop_hold_cycles = 0;
    gaps_on = 1'b1;
    kmer_len_q = khc_pkg::KMER_LEN_RESET;
    window_q = '0;
    run_q = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_short_words();
    test_long_words();
    test_invalid_and_restart();
    test_backpressure();
    test_random_phases();
    test_steady_stream();

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[kmer_histogram_counter_unit] OK");
    end else begin
      $display("[kmer_histogram_counter_unit] ERROR");
    end
    $finish;
  end

endmodule

@@ kmer_histogram_counter_unit.f @@
+incdir+rtl
rtl/khc_pkg.sv
rtl/khc_queue.sv
rtl/khc_front.sv
rtl/khc_back.sv
rtl/kmer_histogram_counter_unit.sv
verif/kmer_histogram_counter_unit_tb.sv
